>>> src/spat_pkg.sv
// Package with the types, field positions and codes of the segment and page address translator.
`default_nettype none
package spat_pkg;

   localparam int DEFAULT_GDT_DEPTH = 256;
   localparam int DEFAULT_LDT_DEPTH = 256;
   localparam int DEFAULT_PD_DEPTH  = 1024;
   localparam int DEFAULT_PT_DEPTH  = 1024;

   localparam int SEL_TABLE_BIT  = 2;
   localparam int SEL_INDEX_LSB  = 3;
   localparam int SEL_INDEX_W    = 13;
   localparam int DESC_PRESENT   = 15;
   localparam int BASE_LO_LSB    = 16;
   localparam int BASE_LO_W      = 16;
   localparam int BASE_MID_LSB   = 32;
   localparam int BASE_MID_W     = 8;
   localparam int BASE_HI_LSB    = 56;
   localparam int BASE_HI_W      = 8;
   localparam int DIR_LSB        = 22;
   localparam int DIR_W          = 10;
   localparam int TBL_LSB        = 12;
   localparam int TBL_W          = 10;
   localparam int PAGE_OFS_LSB   = 0;
   localparam int PAGE_OFS_W     = 12;
   localparam int FRAME_LSB      = 12;
   localparam int FRAME_W        = 20;
   localparam int ENTRY_PRESENT  = 0;

   localparam int GDT_COUNT_W = 9;
   localparam int LDT_COUNT_W = 9;
   localparam int PD_COUNT_W  = 11;
   localparam int PT_COUNT_W  = 11;
   localparam int CSR_DATA_W  = 11;

   typedef enum logic [2:0] {
      MODE_TRANSLATE = 3'd0,
      MODE_WRITE_GDT = 3'd1,
      MODE_WRITE_LDT = 3'd2,
      MODE_WRITE_PD  = 3'd3,
      MODE_WRITE_PT  = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      CSR_GDT_COUNT = 2'd0,
      CSR_LDT_COUNT = 2'd1,
      CSR_PD_COUNT  = 2'd2,
      CSR_PT_COUNT  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [9:0]  table_index;
      logic [63:0] entry_data;
      logic [15:0] selector;
      logic [31:0] offset;
   } req_type;

   typedef struct packed {
      logic        fault;
      logic [31:0] phys_addr;
   } rsp_type;

   typedef struct packed {
      logic        xlate;
      logic        wr_pd;
      logic        wr_pt;
      logic [9:0]  table_index;
      logic [31:0] entry_data;
      logic        use_ldt;
      logic        fault;
      logic [31:0] offset;
   } s1_type;

   typedef struct packed {
      logic        xlate;
      logic        wr_pd;
      logic        wr_pt;
      logic [9:0]  table_index;
      logic [31:0] entry_data;
      logic        fault;
      logic [31:0] linear;
   } s2_type;

   typedef struct packed {
      logic        xlate;
      logic        fault;
      logic [PAGE_OFS_W-1:0] page_offset;
   } s3_type;

endpackage
`default_nettype wire

>>> src/spat_ram.sv
// Generic single-write, single-read memory with a registered read port.
`default_nettype none
module spat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

>>> src/segment_page_address_translate_top.sv
// Top level of the segment and page address translator: four-stage lookup pipeline.
//
//   Channel   Ports                                   Direction
//   request   start, busy, req_payload                in
//   result    rsp_valid, rsp_payload                  out
//   csr       csr_write_en, csr_index, csr_wdata      in
//
// One request is accepted every cycle while busy is low. A translate request gives its result
// after these steps in order: descriptor read, linear add, page entry reads, result.
// Page table writes travel down the pipeline and land in the same stage as the reads,
// so requests take effect strictly in order. Table writes give no result.
// Busy is high only during reset; the result strobe lasts one cycle and is not held.
`default_nettype none
module segment_page_address_translate_top #(
   parameter int GDT_DEPTH = spat_pkg::DEFAULT_GDT_DEPTH,
   parameter int LDT_DEPTH = spat_pkg::DEFAULT_LDT_DEPTH,
   parameter int PD_DEPTH  = spat_pkg::DEFAULT_PD_DEPTH,
   parameter int PT_DEPTH  = spat_pkg::DEFAULT_PT_DEPTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire spat_pkg::req_type                   req_payload,
   output logic                                     rsp_valid,
   output spat_pkg::rsp_type                        rsp_payload,
   input  wire logic                                csr_write_en,
   input  wire logic [1:0]                          csr_index,
   input  wire logic [spat_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int GdtAw = (GDT_DEPTH > 1) ? $clog2(GDT_DEPTH) : 1;
   localparam int LdtAw = (LDT_DEPTH > 1) ? $clog2(LDT_DEPTH) : 1;
   localparam int PdAw  = (PD_DEPTH > 1) ? $clog2(PD_DEPTH) : 1;
   localparam int PtAw  = (PT_DEPTH > 1) ? $clog2(PT_DEPTH) : 1;

   logic [spat_pkg::GDT_COUNT_W-1:0] gdt_count_ff;
   logic [spat_pkg::LDT_COUNT_W-1:0] ldt_count_ff;
   logic [spat_pkg::PD_COUNT_W-1:0]  pd_count_ff;
   logic [spat_pkg::PT_COUNT_W-1:0]  pt_count_ff;

   spat_pkg::s1_type s1_ff, s1_in;
   spat_pkg::s2_type s2_ff, s2_in;
   spat_pkg::s3_type s3_ff, s3_in;
   logic              rsp_valid_ff, rsp_valid_in;
   spat_pkg::rsp_type rsp_payload_ff, rsp_payload_in;

   logic        accept;
   logic        is_xlate;
   logic [12:0] desc_index;
   logic        use_ldt;
   logic        gdt_wr_en, ldt_wr_en;
   logic [63:0] gdt_rd_data, ldt_rd_data, desc;
   logic [31:0] base;
   logic [9:0]  dir_index, tbl_index;
   logic        page_range_fault;
   logic [31:0] pde, pte;
   logic        final_fault;

   assign busy   = reset;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         gdt_count_ff <= '0;
         ldt_count_ff <= '0;
         pd_count_ff  <= '0;
         pt_count_ff  <= '0;
      end else if (csr_write_en) begin
         unique case (spat_pkg::csr_index_type'(csr_index))
            spat_pkg::CSR_GDT_COUNT: begin
               gdt_count_ff <= csr_wdata[spat_pkg::GDT_COUNT_W-1:0];
            end
            spat_pkg::CSR_LDT_COUNT: begin
               ldt_count_ff <= csr_wdata[spat_pkg::LDT_COUNT_W-1:0];
            end
            spat_pkg::CSR_PD_COUNT: begin
               pd_count_ff <= csr_wdata[spat_pkg::PD_COUNT_W-1:0];
            end
            spat_pkg::CSR_PT_COUNT: begin
               pt_count_ff <= csr_wdata[spat_pkg::PT_COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Stage 0: decode, descriptor range check, descriptor table access.
   assign is_xlate   = accept && (req_payload.mode == spat_pkg::MODE_TRANSLATE);
   assign use_ldt    = req_payload.selector[spat_pkg::SEL_TABLE_BIT];
   assign desc_index = req_payload.selector[spat_pkg::SEL_INDEX_LSB +: spat_pkg::SEL_INDEX_W];
   assign gdt_wr_en  = accept && (req_payload.mode == spat_pkg::MODE_WRITE_GDT)
                       && (32'(req_payload.table_index) < GDT_DEPTH);
   assign ldt_wr_en  = accept && (req_payload.mode == spat_pkg::MODE_WRITE_LDT)
                       && (32'(req_payload.table_index) < LDT_DEPTH);

   always_comb begin
      s1_in             = '0;
      s1_in.xlate       = is_xlate;
      s1_in.wr_pd       = accept && (req_payload.mode == spat_pkg::MODE_WRITE_PD)
                          && (32'(req_payload.table_index) < PD_DEPTH);
      s1_in.wr_pt       = accept && (req_payload.mode == spat_pkg::MODE_WRITE_PT)
                          && (32'(req_payload.table_index) < PT_DEPTH);
      s1_in.table_index = req_payload.table_index;
      s1_in.entry_data  = req_payload.entry_data[31:0];
      s1_in.use_ldt     = use_ldt;
      s1_in.offset      = req_payload.offset;
      if (use_ldt) begin
         s1_in.fault = (desc_index >= 13'(ldt_count_ff)) || (32'(desc_index) >= LDT_DEPTH);
      end else begin
         s1_in.fault = (desc_index == '0) || (desc_index >= 13'(gdt_count_ff))
                       || (32'(desc_index) >= GDT_DEPTH);
      end
   end

   spat_ram #(.WIDTH(64), .DEPTH(GDT_DEPTH)) u_gdt_ram (
      .clock   (clock),
      .wr_en   (gdt_wr_en),
      .wr_addr (GdtAw'(req_payload.table_index)),
      .wr_data (req_payload.entry_data),
      .rd_addr (GdtAw'(desc_index)),
      .rd_data (gdt_rd_data)
   );

   spat_ram #(.WIDTH(64), .DEPTH(LDT_DEPTH)) u_ldt_ram (
      .clock   (clock),
      .wr_en   (ldt_wr_en),
      .wr_addr (LdtAw'(req_payload.table_index)),
      .wr_data (req_payload.entry_data),
      .rd_addr (LdtAw'(desc_index)),
      .rd_data (ldt_rd_data)
   );

   // Stage 1: present check, base assembly and linear address.
   assign desc = s1_ff.use_ldt ? ldt_rd_data : gdt_rd_data;
   assign base = {desc[spat_pkg::BASE_HI_LSB +: spat_pkg::BASE_HI_W],
                  desc[spat_pkg::BASE_MID_LSB +: spat_pkg::BASE_MID_W],
                  desc[spat_pkg::BASE_LO_LSB +: spat_pkg::BASE_LO_W]};

   always_comb begin
      s2_in             = '0;
      s2_in.xlate       = s1_ff.xlate;
      s2_in.wr_pd       = s1_ff.wr_pd;
      s2_in.wr_pt       = s1_ff.wr_pt;
      s2_in.table_index = s1_ff.table_index;
      s2_in.entry_data  = s1_ff.entry_data;
      s2_in.fault       = s1_ff.fault || !desc[spat_pkg::DESC_PRESENT];
      s2_in.linear      = base + s1_ff.offset;
   end

   // Stage 2: page range checks, page table access and delayed page table writes.
   assign dir_index = s2_ff.linear[spat_pkg::DIR_LSB +: spat_pkg::DIR_W];
   assign tbl_index = s2_ff.linear[spat_pkg::TBL_LSB +: spat_pkg::TBL_W];
   assign page_range_fault = (11'(dir_index) >= pd_count_ff) || (32'(dir_index) >= PD_DEPTH)
                             || (11'(tbl_index) >= pt_count_ff) || (32'(tbl_index) >= PT_DEPTH);

   always_comb begin
      s3_in             = '0;
      s3_in.xlate       = s2_ff.xlate;
      s3_in.fault       = s2_ff.fault || page_range_fault;
      s3_in.page_offset = s2_ff.linear[spat_pkg::PAGE_OFS_LSB +: spat_pkg::PAGE_OFS_W];
   end

   spat_ram #(.WIDTH(32), .DEPTH(PD_DEPTH)) u_pd_ram (
      .clock   (clock),
      .wr_en   (s2_ff.wr_pd),
      .wr_addr (PdAw'(s2_ff.table_index)),
      .wr_data (s2_ff.entry_data),
      .rd_addr (PdAw'(dir_index)),
      .rd_data (pde)
   );

   spat_ram #(.WIDTH(32), .DEPTH(PT_DEPTH)) u_pt_ram (
      .clock   (clock),
      .wr_en   (s2_ff.wr_pt),
      .wr_addr (PtAw'(s2_ff.table_index)),
      .wr_data (s2_ff.entry_data),
      .rd_addr (PtAw'(tbl_index)),
      .rd_data (pte)
   );

   // Stage 3: entry present checks and physical address.
   assign final_fault  = s3_ff.fault || !pde[spat_pkg::ENTRY_PRESENT]
                         || !pte[spat_pkg::ENTRY_PRESENT];
   assign rsp_valid_in = s3_ff.xlate;

   always_comb begin
      rsp_payload_in       = '0;
      rsp_payload_in.fault = final_fault;
      if (!final_fault) begin
         rsp_payload_in.phys_addr = {pte[spat_pkg::FRAME_LSB +: spat_pkg::FRAME_W],
                                     s3_ff.page_offset};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         s2_ff        <= '0;
         s3_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         s3_ff        <= s3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef ASSERT_OFF
   // A result strobe appears only after an accepted translate request.
   a_rsp_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(is_xlate, 4))
      else $error("result strobe without a translate request");

   a_request_has_rsp: assert property (@(posedge clock) disable iff (reset)
      is_xlate |-> ##4 rsp_valid)
      else $error("translate request produced no result");

   // Page entry reads and delayed page writes never share stage 2.
   a_stage2_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0({s2_ff.xlate, s2_ff.wr_pd, s2_ff.wr_pt}))
      else $error("page table read and write collide in stage 2");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.fault |-> rsp_payload.phys_addr == '0)
      else $error("faulting result carries a nonzero address");
`endif

endmodule
`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the segment and page address translator.
`timescale 1ns / 100ps
module testbench;
   import spat_pkg::*;

   localparam int GDT_DEPTH    = DEFAULT_GDT_DEPTH;
   localparam int LDT_DEPTH    = DEFAULT_LDT_DEPTH;
   localparam int PD_DEPTH     = DEFAULT_PD_DEPTH;
   localparam int PT_DEPTH     = DEFAULT_PT_DEPTH;
   localparam int DRAIN_CYCLES = 10;
   localparam int STALL_LIMIT  = 2000;
   localparam int PHASE_ITEMS  = 84;
   localparam int PHASE_WRITES = 16;
   localparam logic [2:0] MODE_RESERVED_LO = 3'd5;
   localparam logic [2:0] MODE_RESERVED_HI = 3'd7;

   class address_scoreboard;
      logic [63:0] gdt_mem [GDT_DEPTH];
      logic [63:0] ldt_mem [LDT_DEPTH];
      logic [31:0] pd_mem [PD_DEPTH];
      logic [31:0] pt_mem [PT_DEPTH];
      bit gdt_set [GDT_DEPTH];
      bit ldt_set [LDT_DEPTH];
      bit pd_set [PD_DEPTH];
      bit pt_set [PT_DEPTH];
      int gdt_filled[$];
      int ldt_filled[$];
      int pd_filled[$];
      int pt_filled[$];
      logic [GDT_COUNT_W-1:0] gdt_count = '0;
      logic [LDT_COUNT_W-1:0] ldt_count = '0;
      logic [PD_COUNT_W-1:0]  pd_count = '0;
      logic [PT_COUNT_W-1:0]  pt_count = '0;
      rsp_type expected_addresses[$];
      int mismatches = 0;

      function logic [31:0] segment_base(logic [63:0] desc);
         return {desc[63:56], desc[39:32], desc[31:16]};
      endfunction

      function void set_count(csr_index_type which, logic [CSR_DATA_W-1:0] value);
         case (which)
            CSR_GDT_COUNT: gdt_count = value[GDT_COUNT_W-1:0];
            CSR_LDT_COUNT: ldt_count = value[LDT_COUNT_W-1:0];
            CSR_PD_COUNT:  pd_count = value[PD_COUNT_W-1:0];
            CSR_PT_COUNT:  pt_count = value[PT_COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      function rsp_type translate(input logic [15:0] sel, input logic [31:0] ofs,
                                  output bit unwritten);
         rsp_type res;
         logic [12:0] idx;
         logic [63:0] desc;
         logic [31:0] linear;
         logic [31:0] pde;
         logic [31:0] pte;
         logic [9:0] dir;
         logic [9:0] tbl;
         res.fault = 1'b1;
         res.phys_addr = '0;
         unwritten = 1'b0;
         idx = sel[15:3];
         if (sel[SEL_TABLE_BIT]) begin
            if (idx >= ldt_count || idx >= LDT_DEPTH) return res;
            desc = ldt_mem[idx];
            unwritten = !ldt_set[idx];
         end else begin
            if (idx == 0 || idx >= gdt_count || idx >= GDT_DEPTH) return res;
            desc = gdt_mem[idx];
            unwritten = !gdt_set[idx];
         end
         if (unwritten || !desc[DESC_PRESENT]) return res;
         linear = segment_base(desc) + ofs;
         dir = linear[31:22];
         tbl = linear[21:12];
         if (dir >= pd_count || tbl >= pt_count) return res;
         unwritten = !pd_set[dir] || !pt_set[tbl];
         if (unwritten) return res;
         pde = pd_mem[dir];
         pte = pt_mem[tbl];
         if (!pde[ENTRY_PRESENT] || !pte[ENTRY_PRESENT]) return res;
         res.fault = 1'b0;
         res.phys_addr = {pte[31:12], linear[11:0]};
         return res;
      endfunction

      function void note_request(req_type r);
         bit unwritten;
         case (r.mode)
            MODE_TRANSLATE:
               expected_addresses.push_back(translate(r.selector, r.offset, unwritten));
            MODE_WRITE_GDT: if (r.table_index < GDT_DEPTH) begin
               if (!gdt_set[r.table_index]) gdt_filled.push_back(r.table_index);
               gdt_set[r.table_index] = 1'b1;
               gdt_mem[r.table_index] = r.entry_data;
            end
            MODE_WRITE_LDT: if (r.table_index < LDT_DEPTH) begin
               if (!ldt_set[r.table_index]) ldt_filled.push_back(r.table_index);
               ldt_set[r.table_index] = 1'b1;
               ldt_mem[r.table_index] = r.entry_data;
            end
            MODE_WRITE_PD: begin
               if (!pd_set[r.table_index]) pd_filled.push_back(r.table_index);
               pd_set[r.table_index] = 1'b1;
               pd_mem[r.table_index] = r.entry_data[31:0];
            end
            MODE_WRITE_PT: begin
               if (!pt_set[r.table_index]) pt_filled.push_back(r.table_index);
               pt_set[r.table_index] = 1'b1;
               pt_mem[r.table_index] = r.entry_data[31:0];
            end
            default: ;
         endcase
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_addresses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: fault %0b address %08h",
                        got.fault, got.phys_addr);
            return;
         end
         want = expected_addresses.pop_front();
         if (got.fault !== want.fault || got.phys_addr !== want.phys_addr) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"translation mismatch: expected fault %0b address %08h, ",
                         "got fault %0b address %08h"},
                        want.fault, want.phys_addr, got.fault, got.phys_addr);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_payload = '0;
   logic rsp_valid;
   rsp_type rsp_payload;
   logic csr_write_en = 1'b0;
   logic [1:0] csr_index = CSR_GDT_COUNT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   address_scoreboard board;
   address_scoreboard plan;
   int idle_pct = 0;
   int quiet_cycles = 0;

   segment_page_address_translate_top u_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) board.check_result(rsp_payload);
         if (start && !busy) board.note_request(req_payload);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic req_type random_payload();
      req_type r;
      r.mode = 3'($urandom_range(7));
      r.table_index = 10'($urandom_range(1023));
      r.entry_data = {$urandom, $urandom};
      r.selector = 16'($urandom_range(65535));
      r.offset = $urandom;
      return r;
   endfunction

   function automatic req_type make_req(logic [2:0] mode, logic [9:0] index,
                                        logic [63:0] data, logic [15:0] sel,
                                        logic [31:0] ofs);
      req_type r;
      r.mode = mode;
      r.table_index = index;
      r.entry_data = data;
      r.selector = sel;
      r.offset = ofs;
      return r;
   endfunction

   function automatic logic [63:0] make_descriptor(logic [31:0] base, logic present);
      logic [63:0] desc;
      desc = {$urandom, $urandom};
      desc[31:16] = base[15:0];
      desc[39:32] = base[23:16];
      desc[63:56] = base[31:24];
      desc[DESC_PRESENT] = present;
      return desc;
   endfunction

   // A translation that would look at a table entry never written gets a null selector instead.
   function automatic req_type avoid_unwritten(req_type r);
      bit unwritten;
      void'(plan.translate(r.selector, r.offset, unwritten));
      if (unwritten) r.selector[15:2] = '0;
      return r;
   endfunction

   function automatic req_type table_write();
      req_type r;
      int depth;
      int limit;
      r = random_payload();
      r.mode = mode_type'($urandom_range(MODE_WRITE_GDT, MODE_WRITE_PT));
      case (r.mode)
         MODE_WRITE_GDT: begin depth = GDT_DEPTH; limit = plan.gdt_count; end
         MODE_WRITE_LDT: begin depth = LDT_DEPTH; limit = plan.ldt_count; end
         MODE_WRITE_PD:  begin depth = PD_DEPTH;  limit = plan.pd_count;  end
         default:        begin depth = PT_DEPTH;  limit = plan.pt_count;  end
      endcase
      if (limit > depth) limit = depth;
      if (limit > 0 && $urandom_range(99) < 80) r.table_index = 10'($urandom_range(limit - 1));
      if (r.mode == MODE_WRITE_GDT || r.mode == MODE_WRITE_LDT)
         r.entry_data[DESC_PRESENT] = ($urandom_range(99) < 85);
      else
         r.entry_data[ENTRY_PRESENT] = ($urandom_range(99) < 85);
      return r;
   endfunction

   function automatic req_type mapped_translate();
      req_type r;
      logic [63:0] desc;
      logic [31:0] linear;
      logic [12:0] idx;
      bit ldt;
      int n;
      r = random_payload();
      r.mode = MODE_TRANSLATE;
      ldt = $urandom_range(1);
      n = ldt ? plan.ldt_filled.size() : plan.gdt_filled.size();
      if (n == 0) return avoid_unwritten(r);
      idx = ldt ? 13'(plan.ldt_filled[$urandom_range(n - 1)])
                : 13'(plan.gdt_filled[$urandom_range(n - 1)]);
      desc = ldt ? plan.ldt_mem[idx] : plan.gdt_mem[idx];
      r.selector = {idx, ldt, r.selector[1:0]};
      if (plan.pd_filled.size() != 0 && plan.pt_filled.size() != 0) begin
         linear = {10'(plan.pd_filled[$urandom_range(plan.pd_filled.size() - 1)]),
                   10'(plan.pt_filled[$urandom_range(plan.pt_filled.size() - 1)]),
                   r.offset[11:0]};
         r.offset = linear - plan.segment_base(desc);
      end
      return avoid_unwritten(r);
   endfunction

   task automatic issue(req_type r);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      start <= 1'b1;
      req_payload <= r;
      plan.note_request(r);
      do @(posedge clock); while (busy);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (board.expected_addresses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic drive_csr(csr_index_type which, int value);
      csr_write_en <= 1'b1;
      csr_index <= which;
      csr_wdata <= CSR_DATA_W'(value);
      board.set_count(which, CSR_DATA_W'(value));
      plan.set_count(which, CSR_DATA_W'(value));
      @(posedge clock);
   endtask

   task automatic program_counts(int gdt, int ldt, int pd, int pt);
      drive_csr(CSR_GDT_COUNT, gdt);
      drive_csr(CSR_LDT_COUNT, ldt);
      drive_csr(CSR_PD_COUNT, pd);
      drive_csr(CSR_PT_COUNT, pt);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      req_type r;
      int pick;
      int issued;
      board = new();
      plan = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      program_counts(3, 2, 2, 4);
      issue(make_req(MODE_WRITE_GDT, 10'd1, make_descriptor(32'hFFFF_F000, 1'b1), '0, '0));
      issue(make_req(MODE_WRITE_GDT, 10'd2, make_descriptor(32'h0040_0000, 1'b0), '0, '0));
      issue(make_req(MODE_WRITE_GDT, 10'h3FF, '1, '1, '1));
      issue(make_req(MODE_WRITE_LDT, 10'd0, make_descriptor(32'h0000_0000, 1'b1), '0, '0));
      issue(make_req(MODE_WRITE_LDT, 10'd1, make_descriptor(32'h0000_3000, 1'b1), '0, '0));
      issue(make_req(MODE_WRITE_PD, 10'd0, 64'hFFFF_FFFF_FFFF_F001, '0, '0));
      issue(make_req(MODE_WRITE_PD, 10'd1, 64'h0000_0000_FFFF_FFFE, '0, '0));
      issue(make_req(MODE_WRITE_PT, 10'd0, 64'h0000_0000_FFFF_FFFF, '0, '0));
      issue(make_req(MODE_WRITE_PT, 10'd1, 64'h5A5A_5A5A_1234_5001, '0, '0));
      issue(make_req(MODE_WRITE_PT, 10'd2, 64'h0000_0000_ABCD_E000, '0, '0));
      issue(make_req(MODE_WRITE_PT, 10'd3, 64'h0000_0000_0000_1001, '0, '0));
      for (int m = MODE_RESERVED_LO; m <= MODE_RESERVED_HI; m++)
         issue(make_req(3'(m), '1, '1, '1, '1));
      issue(make_req(MODE_TRANSLATE, '0, '0, 16'h0000, 32'h0000_0000));
      issue(make_req(MODE_TRANSLATE, '1, '1, 16'h0008, 32'h0000_1ABC));
      issue(make_req(MODE_TRANSLATE, '0, '0, 16'h0010, 32'h0000_0000));
      issue(make_req(MODE_TRANSLATE, '0, '0, 16'h0018, 32'h0000_0000));
      issue(make_req(MODE_TRANSLATE, '0, '0, 16'hFFFF, 32'h0000_0000));
      issue(make_req(MODE_TRANSLATE, '0, '0, 16'h0004, 32'h0000_1FFF));
      issue(make_req(MODE_TRANSLATE, '0, '0, 16'h0004, 32'h0000_2000));
      issue(make_req(MODE_TRANSLATE, '0, '0, 16'h0004, 32'h0040_0000));
      issue(make_req(MODE_TRANSLATE, '0, '0, 16'h0004, 32'hFFFF_FFFF));
      issue(make_req(MODE_TRANSLATE, '0, '0, 16'h0004, 32'h0000_4000));
      issue(make_req(MODE_TRANSLATE, '0, '0, 16'h0014, 32'h0000_0000));
      issue(make_req(MODE_TRANSLATE, '0, '0, 16'h000F, 32'h0000_0123));
      settle();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  program_counts(256, 256, 1024, 1024); end
            1: begin
               idle_pct = 58;
               program_counts($urandom_range(256), $urandom_range(256),
                              $urandom_range(1024), $urandom_range(1024));
            end
            2: begin idle_pct = 33; program_counts(0, 0, 0, 0); end
            3: begin idle_pct = 0;  program_counts(1, 1, 1, 1); end
            4: begin
               idle_pct = 58;
               program_counts($urandom_range(256), $urandom_range(256),
                              $urandom_range(1024), $urandom_range(1024));
            end
            default: begin idle_pct = 33; program_counts(256, 256, 1024, 1024); end
         endcase
         issued = 0;
         while (issued < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (issued < PHASE_WRITES || pick < 20) begin
               r = table_write();
            end else if (pick < 78) begin
               r = mapped_translate();
            end else if (pick < 95) begin
               r = random_payload();
               r.mode = MODE_TRANSLATE;
               r = avoid_unwritten(r);
            end else begin
               r = random_payload();
               r.mode = 3'($urandom_range(MODE_RESERVED_LO, MODE_RESERVED_HI));
            end
            issue(r);
            if (r.mode <= MODE_WRITE_PT) issued++;
         end
         settle();
      end

      if (board.mismatches == 0 && board.expected_addresses.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

>>> filelist.f
src/spat_pkg.sv
src/spat_ram.sv
src/segment_page_address_translate_top.sv
test/testbench.sv
